### hw/rtl/ckt_pkg.sv
// Shared types and constants for the compacting key table.
package ckt_pkg;

    localparam int CAPACITY = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int KEY_W    = 31;

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_DELETE = 2'd1;
    localparam logic [1:0] REQ_SEARCH = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [1:0]       req_type;
        logic [KEY_W-1:0] key;
    } ckt_req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [ADDR_W-1:0] position;
        logic [CNT_W-1:0]  compare_count;
        logic [CNT_W-1:0]  entry_count;
    } ckt_rsp_t;

endpackage

### hw/rtl/compacting_key_table.sv
// Top level of the compacting key table: request sequencer around the key RAM.
//
// Requests arrive on req (req_valid/req_stall) and each one gives exactly one
// response on rsp (rsp_valid/rsp_stall). A request is an insert, a delete or
// a search of one 31-bit key; keys are held in insertion order at indices
// 0 .. entry_count-1 of a single-port-pair RAM with registered read data.
// One request is worked on at a time; req_stall is high while it runs.
// Steps after the transfer, with n entries held and a match at index i:
//   search/insert: a walk over the entries in order, one read a cycle,
//     until a match or the end, then the result state
//   delete: the walk, then the n-i-1 later keys are moved down one slot,
//     one read and one write a cycle plus drain, then the result state;
//   the block returns to idle before it takes the next transfer.
// A response sits in an output register, so a new request is taken while
// the previous response is still stalled; a finished request then waits
// until that register empties. rsp holds steady while rsp_stall is high.
// Reset clears the entry count and all control state; the RAM is not
// cleared, since only entries below the count are ever read.
module compacting_key_table (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_stall,
    input  ckt_pkg::ckt_req_t req,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output ckt_pkg::ckt_rsp_t rsp
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_SHIFT,
        S_RESULT
    } state_t;

    state_t                          state_reg;
    logic [1:0]                      op_reg;
    logic [ckt_pkg::KEY_W-1:0]       key_reg;
    logic [ckt_pkg::CNT_W-1:0]       fill_reg;
    logic [ckt_pkg::CNT_W-1:0]       issue_reg;
    logic                            pend_valid_reg;
    logic [ckt_pkg::ADDR_W-1:0]      pend_idx_reg;
    logic [1:0]                      status_reg;
    logic [ckt_pkg::ADDR_W-1:0]      pos_reg;
    logic [ckt_pkg::CNT_W-1:0]       cmp_reg;
    logic                            rsp_valid_reg;
    ckt_pkg::ckt_rsp_t               rsp_reg;

    logic                            ram_wr_en;
    logic [ckt_pkg::ADDR_W-1:0]      ram_wr_addr;
    logic [ckt_pkg::KEY_W-1:0]       ram_wr_data;
    logic                            ram_rd_en;
    logic [ckt_pkg::ADDR_W-1:0]      ram_rd_addr;
    logic [ckt_pkg::KEY_W-1:0]       ram_rd_data;

    logic                            issue_more;
    logic                            match;
    logic                            walk_miss;
    logic                            full;
    logic                            rsp_free;
    logic                            rsp_load;

    assign issue_more = issue_reg < fill_reg;
    assign match      = pend_valid_reg && (ram_rd_data == key_reg);
    assign walk_miss  = !match && !issue_more;
    assign full       = fill_reg == ckt_pkg::CNT_W'(ckt_pkg::CAPACITY);
    assign rsp_free   = !rsp_valid_reg || !rsp_stall;
    assign rsp_load   = (state_reg == S_RESULT) && rsp_free;

    assign req_stall = state_reg != S_IDLE;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        ram_rd_en   = ((state_reg == S_WALK) || (state_reg == S_SHIFT)) && issue_more;
        ram_rd_addr = issue_reg[ckt_pkg::ADDR_W-1:0];
        ram_wr_en   = 1'b0;
        ram_wr_addr = fill_reg[ckt_pkg::ADDR_W-1:0];
        ram_wr_data = key_reg;
        if (state_reg == S_SHIFT)
        begin
            ram_wr_en   = pend_valid_reg;
            ram_wr_addr = pend_idx_reg;
            ram_wr_data = ram_rd_data;
        end
        else if (state_reg == S_WALK)
        begin
            ram_wr_en = walk_miss && (op_reg == ckt_pkg::REQ_INSERT) && !full;
        end
    end

    ckt_ram #(
        .WIDTH (ckt_pkg::KEY_W),
        .DEPTH (ckt_pkg::CAPACITY)
    ) u_key_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            op_reg         <= ckt_pkg::REQ_INSERT;
            key_reg        <= '0;
            fill_reg       <= '0;
            issue_reg      <= '0;
            pend_valid_reg <= 1'b0;
            pend_idx_reg   <= '0;
            status_reg     <= ckt_pkg::ST_MISS;
            pos_reg        <= '0;
            cmp_reg        <= '0;
            rsp_valid_reg  <= 1'b0;
            rsp_reg        <= '0;
        end
        else
        begin
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (req_valid)
                    begin
                        op_reg         <= req.req_type;
                        key_reg        <= req.key;
                        issue_reg      <= '0;
                        pend_valid_reg <= 1'b0;
                        status_reg     <= ckt_pkg::ST_MISS;
                        pos_reg        <= '0;
                        cmp_reg        <= '0;
                        if (req.req_type == ckt_pkg::REQ_INSERT
                            || req.req_type == ckt_pkg::REQ_DELETE
                            || req.req_type == ckt_pkg::REQ_SEARCH)
                        begin
                            state_reg <= S_WALK;
                        end
                        else
                        begin
                            state_reg <= S_RESULT;
                        end
                    end
                end
                S_WALK:
                begin
                    pend_idx_reg <= issue_reg[ckt_pkg::ADDR_W-1:0];
                    if (match && op_reg == ckt_pkg::REQ_DELETE)
                    begin
                        issue_reg      <= {1'b0, pend_idx_reg} + 1'b1;
                        pend_valid_reg <= 1'b0;
                    end
                    else
                    begin
                        pend_valid_reg <= issue_more;
                        if (issue_more)
                        begin
                            issue_reg <= issue_reg + 1'b1;
                        end
                    end
                    if (match)
                    begin
                        cmp_reg <= {1'b0, pend_idx_reg} + 1'b1;
                        if (op_reg == ckt_pkg::REQ_INSERT)
                        begin
                            status_reg <= ckt_pkg::ST_MISS;
                            pos_reg    <= '0;
                            state_reg  <= S_RESULT;
                        end
                        else if (op_reg == ckt_pkg::REQ_DELETE)
                        begin
                            status_reg <= ckt_pkg::ST_OK;
                            pos_reg    <= pend_idx_reg;
                            state_reg  <= S_SHIFT;
                        end
                        else
                        begin
                            status_reg <= ckt_pkg::ST_OK;
                            pos_reg    <= pend_idx_reg;
                            state_reg  <= S_RESULT;
                        end
                    end
                    else if (walk_miss)
                    begin
                        cmp_reg   <= fill_reg;
                        state_reg <= S_RESULT;
                        if (op_reg == ckt_pkg::REQ_INSERT && full)
                        begin
                            status_reg <= ckt_pkg::ST_FULL;
                            pos_reg    <= '0;
                        end
                        else if (op_reg == ckt_pkg::REQ_INSERT)
                        begin
                            status_reg <= ckt_pkg::ST_OK;
                            pos_reg    <= fill_reg[ckt_pkg::ADDR_W-1:0];
                            fill_reg   <= fill_reg + 1'b1;
                        end
                        else
                        begin
                            status_reg <= ckt_pkg::ST_MISS;
                            pos_reg    <= '0;
                        end
                    end
                end
                S_SHIFT:
                begin
                    // read slot j, write it to slot j-1 on the next cycle
                    pend_valid_reg <= issue_more;
                    pend_idx_reg   <= issue_reg[ckt_pkg::ADDR_W-1:0] - 1'b1;
                    if (issue_more)
                    begin
                        issue_reg <= issue_reg + 1'b1;
                    end
                    else if (!pend_valid_reg)
                    begin
                        fill_reg  <= fill_reg - 1'b1;
                        state_reg <= S_RESULT;
                    end
                end
                S_RESULT:
                begin
                    if (rsp_free)
                    begin
                        rsp_reg.status        <= status_reg;
                        rsp_reg.position      <= pos_reg;
                        rsp_reg.compare_count <= cmp_reg;
                        rsp_reg.entry_count   <= fill_reg;
                        state_reg             <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= ckt_pkg::CNT_W'(ckt_pkg::CAPACITY))
        else $error("entry count above capacity");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> state_reg != S_IDLE)
        else $error("accepted request not started");

    a_shift_below_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT) && ram_wr_en |-> ({1'b0, ram_wr_addr} + 1'b1) < fill_reg)
        else $error("compaction write beyond held entries");

    a_rsp_from_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == S_RESULT))
        else $error("response raised outside result state");

    a_one_rsp_per_req: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESULT) && rsp_free |=> rsp_valid_reg && state_reg == S_IDLE)
        else $error("result not loaded into response register");
`endif

endmodule

### hw/rtl/ckt_ram.sv
// Generic simple dual-port RAM with registered read data.
module ckt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
